// ===== rtl/core/xterm_palette_quantizer_macros.svh =====
// ----------------------------------------------------------------------------
// xterm_palette_quantizer_macros.svh
// Assertion shorthands used by the palette quantizer top level.
// ----------------------------------------------------------------------------
`ifndef XTERM_PALETTE_QUANTIZER_MACROS_SVH
`define XTERM_PALETTE_QUANTIZER_MACROS_SVH

// Same-cycle implication, clocked on clock, off while reset is high
`define XPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xpq: same-cycle check failed");

// Next-cycle implication, clocked on clock, off while reset is high
`define XPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xpq: next-cycle check failed");

`endif

// ===== rtl/core/xpq_pkg.sv =====
// ----------------------------------------------------------------------------
// xpq_pkg
// Types, palette constants and small lookup functions for the quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package xpq_pkg;

   // Job kinds carried from the front end to the search engine
   localparam logic [1:0] KIND_BASIC  = 2'd0;  // search entries 0..15
   localparam logic [1:0] KIND_FULL   = 2'd1;  // search entries 16..255
   localparam logic [1:0] KIND_DIRECT = 2'd2;  // index already known

   localparam logic [7:0] BASIC_FIRST = 8'd0;
   localparam logic [7:0] BASIC_LAST  = 8'd15;
   localparam logic [7:0] FULL_FIRST  = 8'd16;
   localparam logic [7:0] FULL_LAST   = 8'd255;
   localparam logic [7:0] GRAY_FIRST  = 8'd232;
   localparam logic [7:0] GRAY_BASE   = 8'd8;
   localparam logic [7:0] GRAY_STEP   = 8'd10;
   localparam logic [7:0] GRAY_CLAMP  = 8'd231;
   localparam logic [4:0] GRAY_Q_MAX  = 5'd23;
   localparam logic [2:0] LEVEL_MAX   = 3'd5;

   // Sum of three 8-bit squares stays below 2^18
   localparam int DIST_W = 18;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [1:0] kind;
      logic [7:0] index;
   } qentry_type;

   typedef struct packed {
      logic busy;
      logic pending;
   } back_status_type;

   // Basic 16-color table, packed as {r, g, b}
   function automatic logic [23:0] basic_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0:    rgb = {8'd0,   8'd0,   8'd0};
         4'd1:    rgb = {8'd205, 8'd0,   8'd0};
         4'd2:    rgb = {8'd0,   8'd205, 8'd0};
         4'd3:    rgb = {8'd205, 8'd205, 8'd0};
         4'd4:    rgb = {8'd0,   8'd0,   8'd238};
         4'd5:    rgb = {8'd205, 8'd0,   8'd205};
         4'd6:    rgb = {8'd0,   8'd205, 8'd205};
         4'd7:    rgb = {8'd229, 8'd229, 8'd229};
         4'd8:    rgb = {8'd127, 8'd127, 8'd127};
         4'd9:    rgb = {8'd255, 8'd0,   8'd0};
         4'd10:   rgb = {8'd0,   8'd255, 8'd0};
         4'd11:   rgb = {8'd255, 8'd255, 8'd0};
         4'd12:   rgb = {8'd92,  8'd92,  8'd255};
         4'd13:   rgb = {8'd255, 8'd0,   8'd255};
         4'd14:   rgb = {8'd0,   8'd255, 8'd255};
         default: rgb = {8'd255, 8'd255, 8'd255};
      endcase
      return rgb;
   endfunction

   // Channel level of one cube digit
   function automatic logic [7:0] cube_level(input logic [2:0] digit);
      logic [7:0] lvl;
      case (digit)
         3'd0:    lvl = 8'd0;
         3'd1:    lvl = 8'd95;
         3'd2:    lvl = 8'd135;
         3'd3:    lvl = 8'd175;
         3'd4:    lvl = 8'd215;
         default: lvl = 8'd255;
      endcase
      return lvl;
   endfunction

   // Threshold one channel onto the cube axis
   function automatic logic [2:0] level_of(input logic [7:0] c);
      logic [2:0] lvl;
      if (c <= 8'd52)       lvl = 3'd0;
      else if (c <= 8'd115) lvl = 3'd1;
      else if (c <= 8'd155) lvl = 3'd2;
      else if (c <= 8'd195) lvl = 3'd3;
      else if (c <= 8'd235) lvl = 3'd4;
      else                  lvl = LEVEL_MAX;
      return lvl;
   endfunction

   // (c - 3) / 10, zero below 3; divide by 10 as multiply by 205 and shift by 11
   function automatic logic [4:0] gray_q(input logic [7:0] c);
      logic [7:0]  off;
      logic [15:0] prod;
      off  = (c < 8'd3) ? 8'd0 : c - 8'd3;
      prod = 16'(off) * 16'd205;
      return prod[15:11];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xpq_front.sv =====
// ----------------------------------------------------------------------------
// xpq_front
// Accepts pixels, holds the mode register and classifies each item into a
// search job or a finished index from the threshold approximation.
// ----------------------------------------------------------------------------
`default_nettype none

module xpq_front import xpq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic       req_palette_select,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       q_full,
   output logic            push_valid,
   output qentry_type      push_entry
);

   logic       fast_mode_ff;
   logic       fast_mode_in;
   logic [4:0] qr;
   logic [4:0] qg;
   logic [4:0] qb;
   logic [7:0] fast_index;

   // Mode register
   always_comb begin
      fast_mode_in = csr_wr_en ? csr_wr_data : fast_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff <= 1'b0;
      end else begin
         fast_mode_ff <= fast_mode_in;
      end
   end

   // Threshold approximation: gray ramp when all channels agree, else cube
   always_comb begin
      qr = gray_q(req_red);
      qg = gray_q(req_green);
      qb = gray_q(req_blue);
      if (qr == qg && qg == qb) begin
         fast_index = (qr > GRAY_Q_MAX) ? GRAY_CLAMP : GRAY_FIRST + 8'(qr);
      end else begin
         fast_index = FULL_FIRST
                    + 8'(level_of(req_red))   * 8'd36
                    + 8'(level_of(req_green)) * 8'd6
                    + 8'(level_of(req_blue));
      end
   end

   // Classify item and hand it to the queue
   always_comb begin
      push_valid       = req_valid;
      req_stall        = q_full;
      push_entry.red   = req_red;
      push_entry.green = req_green;
      push_entry.blue  = req_blue;
      push_entry.index = fast_index;
      if (!req_palette_select) begin
         push_entry.kind = KIND_BASIC;
      end else if (fast_mode_ff) begin
         push_entry.kind = KIND_DIRECT;
      end else begin
         push_entry.kind = KIND_FULL;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/xpq_queue.sv =====
// ----------------------------------------------------------------------------
// xpq_queue
// Short FIFO of classified jobs between the front end and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module xpq_queue import xpq_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   input  wire qentry_type push_entry,
   output logic            q_full,
   output logic            q_valid,
   output qentry_type      q_entry,
   input  wire logic       q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   qentry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      q_full    = (count_ff == CNT_FULL);
      q_valid   = (count_ff != '0);
      q_entry   = mem_ff[rd_ptr_ff];
      do_push   = push_valid && !q_full;
      do_pop    = q_pop && q_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      // advance pointers with wrap at the depth
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/xpq_back.sv =====
// ----------------------------------------------------------------------------
// xpq_back
// Nearest-color search engine: walks the palette one entry per cycle through
// a shared squared-distance unit and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xpq_back import xpq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire qentry_type q_entry,
   output logic            q_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_color_index,
   output back_status_type status
);

   // Scan control
   logic              scan_ff,  scan_in;
   logic [7:0]        idx_ff,   idx_in;
   logic [7:0]        last_ff,  last_in;
   logic [2:0]        cr_ff,    cr_in;
   logic [2:0]        cg_ff,    cg_in;
   logic [2:0]        cb_ff,    cb_in;
   logic [7:0]        gray_ff,  gray_in;
   logic [7:0]        pr_ff,    pg_ff,    pb_ff;
   // Square stage
   logic              p_valid_ff, p_valid_in;
   logic              p_last_ff,  p_last_in;
   logic [7:0]        p_idx_ff;
   logic [15:0]       sq_r_ff, sq_g_ff, sq_b_ff;
   // Compare stage and result
   logic [DIST_W-1:0] best_d_ff,   best_d_in;
   logic [7:0]        best_idx_ff, best_idx_in;
   logic              pending_ff,  pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_index_ff;
   // Datapath wires
   logic [23:0]       basic;
   logic [7:0]        er, eg, eb;
   logic [7:0]        dr, dg, db;
   logic [DIST_W-1:0] sq_sum;
   logic              at_last;
   logic              rsp_load;

   // Pop a job only when the engine and its result slot are free
   always_comb begin
      q_pop          = q_valid && !scan_ff && !p_valid_ff && !pending_ff;
      status.busy    = scan_ff || p_valid_ff;
      status.pending = pending_ff;
      at_last        = (idx_ff == last_ff);
   end

   // Palette entry color for the current index
   always_comb begin
      basic = basic_rgb(idx_ff[3:0]);
      if (idx_ff < FULL_FIRST) begin
         er = basic[23:16];
         eg = basic[15:8];
         eb = basic[7:0];
      end else if (idx_ff < GRAY_FIRST) begin
         er = cube_level(cr_ff);
         eg = cube_level(cg_ff);
         eb = cube_level(cb_ff);
      end else begin
         er = gray_ff;
         eg = gray_ff;
         eb = gray_ff;
      end
      dr = (pr_ff > er) ? pr_ff - er : er - pr_ff;
      dg = (pg_ff > eg) ? pg_ff - eg : eg - pg_ff;
      db = (pb_ff > eb) ? pb_ff - eb : eb - pb_ff;
   end

   // Advance scan index and the cube and gray walkers
   always_comb begin
      scan_in = scan_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      cr_in   = cr_ff;
      cg_in   = cg_ff;
      cb_in   = cb_ff;
      gray_in = gray_ff;
      if (q_pop) begin
         cr_in   = '0;
         cg_in   = '0;
         cb_in   = '0;
         gray_in = GRAY_BASE;
         case (q_entry.kind)
            KIND_BASIC: begin
               scan_in = 1'b1;
               idx_in  = BASIC_FIRST;
               last_in = BASIC_LAST;
            end
            KIND_FULL: begin
               scan_in = 1'b1;
               idx_in  = FULL_FIRST;
               last_in = FULL_LAST;
            end
            default: begin
               scan_in = 1'b0;
            end
         endcase
      end else if (scan_ff) begin
         scan_in = !at_last;
         idx_in  = idx_ff + 8'd1;
         if (idx_ff >= GRAY_FIRST) begin
            gray_in = gray_ff + GRAY_STEP;
         end else if (idx_ff >= FULL_FIRST) begin
            if (cb_ff == LEVEL_MAX) begin
               cb_in = '0;
               if (cg_ff == LEVEL_MAX) begin
                  cg_in = '0;
                  cr_in = cr_ff + 3'd1;
               end else begin
                  cg_in = cg_ff + 3'd1;
               end
            end else begin
               cb_in = cb_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      p_valid_in = scan_ff;
      p_last_in  = scan_ff && at_last;
   end

   // Compare stage: keep the first strict minimum
   always_comb begin
      sq_sum      = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      pending_in  = pending_ff;
      rsp_load    = pending_ff && (!rsp_valid_ff || !rsp_stall);
      if (q_pop) begin
         best_d_in = '1;
         if (q_entry.kind == KIND_DIRECT) begin
            best_idx_in = q_entry.index;
            pending_in  = 1'b1;
         end
      end else if (p_valid_ff) begin
         if (sq_sum < best_d_ff) begin
            best_d_in   = sq_sum;
            best_idx_in = p_idx_ff;
         end
         if (p_last_ff) begin
            pending_in = 1'b1;
         end
      end else if (rsp_load) begin
         pending_in = 1'b0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= 1'b0;
         p_valid_ff   <= 1'b0;
         p_last_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         p_valid_ff   <= p_valid_in;
         p_last_ff    <= p_last_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      cr_ff       <= cr_in;
      cg_ff       <= cg_in;
      cb_ff       <= cb_in;
      gray_ff     <= gray_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      p_idx_ff    <= idx_ff;
      sq_r_ff     <= 16'(dr) * 16'(dr);
      sq_g_ff     <= 16'(dg) * 16'(dg);
      sq_b_ff     <= 16'(db) * 16'(db);
      if (q_pop) begin
         pr_ff <= q_entry.red;
         pg_ff <= q_entry.green;
         pb_ff <= q_entry.blue;
      end
      if (rsp_load) begin
         rsp_index_ff <= best_idx_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;

endmodule

`default_nettype wire

// ===== rtl/core/xterm_palette_quantizer.sv =====
// ----------------------------------------------------------------------------
// xterm_palette_quantizer
// Maps an 8-bit RGB pixel to an xterm 256-color palette index.
// ----------------------------------------------------------------------------
//
//   Channel   Ports        Dir   Payload
//   req       req_valid    in    red, green, blue, palette_select
//   rsp       rsp_valid    out   color_index
//   csr       csr_wr_en    in    fast_mode
//
// Basic-set and full-set searches walk the palette one entry per cycle
// through the single distance unit; threshold-mode items skip the search.
// Threshold-mode throughput is limited by the result slot.
// Reset clears the mode register, the queue and the engine; no memory sweep.
// A stalled rsp holds its index; the queue keeps taking req items until full.
//
`default_nettype none

`include "xterm_palette_quantizer_macros.svh"

module xterm_palette_quantizer import xpq_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic       req_palette_select,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_color_index,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   logic            push_valid;
   qentry_type      push_entry;
   logic            q_full;
   logic            q_valid;
   qentry_type      q_entry;
   logic            q_pop;
   back_status_type back_status;

   // Accept and classify
   xpq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_palette_select (req_palette_select),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_full             (q_full),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   // Job queue
   xpq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   // Search engine and result register
   xpq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_color_index (rsp_color_index),
      .status          (back_status)
   );

   // Engine never scans while a finished index waits
   `XPQ_ASSERT_NOW(a_busy_excl_pending, back_status.busy, !back_status.pending)
   // Jobs leave the queue only into an idle engine
   `XPQ_ASSERT_NOW(a_pop_when_idle, q_pop, !back_status.busy && !back_status.pending)
   // A waiting index survives a stalled output slot
   `XPQ_ASSERT_NEXT(a_pending_holds, back_status.pending && rsp_valid && rsp_stall,
                    back_status.pending)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for xterm_palette_quantizer. Pixels are sent through
// the req channel with random gaps, and results are drained with random
// stalls. A local predictor computes the expected palette index of every
// accepted pixel, and each result is checked in order. Directed cases cover
// channel extremes, distance ties and the threshold boundaries of fast mode.
// Random phases then follow with the mode register switched between them.
// ----------------------------------------------------------------------------
module testbench;
   import xpq_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       palette_select;
   } pixel_type;

   typedef struct packed {
      pixel_type  px;
      logic [7:0] index;
   } color_guess_type;

   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       req_palette_select;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_color_index;
   logic       csr_wr_en;
   logic       csr_wr_data;

   // Local copy of the mode register and the results still to come
   logic            model_fast_mode;
   color_guess_type pending_colors[$];
   int              error_count;
   bit              steady_flow;

   xterm_palette_quantizer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_palette_select (req_palette_select),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_color_index    (rsp_color_index),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Channel value of cube digit d: 0, 95, 135, 175, 215, 255
   function automatic int cube_axis(input int d);
      return (d == 0) ? 0 : 55 + 40 * d;
   endfunction

   // Color of one palette entry, packed {r, g, b}
   function automatic logic [23:0] palette_rgb(input int idx);
      logic [23:0] rgb;
      int          k;
      int          v;
      if (idx < 16) begin
         case (idx)
            0:       rgb = 24'h000000;
            1:       rgb = 24'hCD0000;
            2:       rgb = 24'h00CD00;
            3:       rgb = 24'hCDCD00;
            4:       rgb = 24'h0000EE;
            5:       rgb = 24'hCD00CD;
            6:       rgb = 24'h00CDCD;
            7:       rgb = 24'hE5E5E5;
            8:       rgb = 24'h7F7F7F;
            9:       rgb = 24'hFF0000;
            10:      rgb = 24'h00FF00;
            11:      rgb = 24'hFFFF00;
            12:      rgb = 24'h5C5CFF;
            13:      rgb = 24'hFF00FF;
            14:      rgb = 24'h00FFFF;
            default: rgb = 24'hFFFFFF;
         endcase
      end else if (idx < int'(GRAY_FIRST)) begin
         k   = idx - int'(FULL_FIRST);
         rgb = {8'(cube_axis(k / 36)), 8'(cube_axis((k / 6) % 6)), 8'(cube_axis(k % 6))};
      end else begin
         v   = 8 + 10 * (idx - int'(GRAY_FIRST));
         rgb = {3{8'(v)}};
      end
      return rgb;
   endfunction

   // Gray step of one channel, truncating (c - 3) / 10
   function automatic int gray_step(input logic [7:0] c);
      return (c < 8'd3) ? 0 : (int'(c) - 3) / 10;
   endfunction

   // Cube digit of one channel by threshold
   function automatic int cube_digit(input logic [7:0] c);
      if (c <= 8'd52)  return 0;
      if (c <= 8'd115) return 1;
      if (c <= 8'd155) return 2;
      if (c <= 8'd195) return 3;
      if (c <= 8'd235) return 4;
      return 5;
   endfunction

   function automatic logic [7:0] quantize_pixel(input pixel_type px, input logic fast);
      int          qr;
      int          qg;
      int          qb;
      int          first;
      int          last;
      int          best;
      int          best_dist;
      int          sum_sq;
      int          dr;
      int          dg;
      int          db;
      int          i;
      logic [23:0] rgb;
      // threshold approximation for the 256 set
      if (px.palette_select && fast) begin
         qr = gray_step(px.red);
         qg = gray_step(px.green);
         qb = gray_step(px.blue);
         if (qr == qg && qg == qb) begin
            if (qr > int'(GRAY_Q_MAX)) return GRAY_CLAMP;
            return 8'(int'(GRAY_FIRST) + qr);
         end
         return 8'(int'(FULL_FIRST) + 36 * cube_digit(px.red) + 6 * cube_digit(px.green)
                   + cube_digit(px.blue));
      end
      // exhaustive search, lowest index wins a tie
      first     = px.palette_select ? int'(FULL_FIRST) : 0;
      last      = px.palette_select ? 256 : 16;
      best      = first;
      best_dist = 32'h7FFF_FFFF;
      for (i = first; i < last; i++) begin
         rgb    = palette_rgb(i);
         dr     = int'(px.red) - int'(rgb[23:16]);
         dg     = int'(px.green) - int'(rgb[15:8]);
         db     = int'(px.blue) - int'(rgb[7:0]);
         sum_sq = dr * dr + dg * dg + db * db;
         if (sum_sq < best_dist) begin
            best_dist = sum_sq;
            best      = i;
         end
      end
      return 8'(best);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Idle length: mostly none or short, a few long
   function automatic int pick_delay();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic pixel_type make_pixel(input int r, input int g, input int b,
                                            input bit sel);
      pixel_type px;
      px.red            = 8'(r);
      px.green          = 8'(g);
      px.blue           = 8'(b);
      px.palette_select = sel;
      return px;
   endfunction

   function automatic logic [7:0] clamp_channel(input int v);
      if (v < 0)   return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   // Channel values on either side of a threshold or gray step
   function automatic logic [7:0] boundary_value();
      case ($urandom_range(0, 17))
         0:       return 8'd0;
         1:       return 8'd2;
         2:       return 8'd3;
         3:       return 8'd12;
         4:       return 8'd13;
         5:       return 8'd52;
         6:       return 8'd53;
         7:       return 8'd115;
         8:       return 8'd116;
         9:       return 8'd155;
         10:      return 8'd156;
         11:      return 8'd195;
         12:      return 8'd196;
         13:      return 8'd235;
         14:      return 8'd236;
         15:      return 8'd242;
         16:      return 8'd243;
         default: return 8'd255;
      endcase
   endfunction

   function automatic pixel_type random_pixel(input bit sel);
      pixel_type   px;
      int          base;
      logic [23:0] rgb;
      px.palette_select = sel;
      case ($urandom_range(0, 5))
         // near gray, to hit the gray test of fast mode
         2: begin
            base     = $urandom_range(0, 255);
            px.red   = clamp_channel(base + $urandom_range(0, 8) - 4);
            px.green = clamp_channel(base + $urandom_range(0, 8) - 4);
            px.blue  = clamp_channel(base + $urandom_range(0, 8) - 4);
         end
         3: begin
            px.red   = boundary_value();
            px.green = boundary_value();
            px.blue  = boundary_value();
         end
         // around cube levels and their midpoints, where ties live
         4: begin
            px.red   = clamp_channel(cube_axis($urandom_range(0, 5)) + $urandom_range(0, 50) - 25);
            px.green = clamp_channel(cube_axis($urandom_range(0, 5)) + $urandom_range(0, 50) - 25);
            px.blue  = clamp_channel(cube_axis($urandom_range(0, 5)) + $urandom_range(0, 50) - 25);
         end
         5: begin
            rgb      = palette_rgb($urandom_range(0, 255));
            px.red   = rgb[23:16];
            px.green = rgb[15:8];
            px.blue  = rgb[7:0];
         end
         default: begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
         end
      endcase
      return px;
   endfunction

   // Send one pixel item; valid stays high afterward for a back-to-back item
   task automatic send_pixel(input pixel_type px);
      int              gap;
      color_guess_type guess;
      gap = pick_delay();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_red            <= px.red;
      req_green          <= px.green;
      req_blue           <= px.blue;
      req_palette_select <= px.palette_select;
      do @(posedge clock); while (req_stall);
      guess.px    = px;
      guess.index = quantize_pixel(px, model_fast_mode);
      pending_colors.push_back(guess);
   endtask

   // Drop valid and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   // Write the mode register once the block is idle
   task automatic write_fast_mode(input logic value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      model_fast_mode  = value;
   endtask

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------

   // Basic 16 set: extremes, exact entries, and a tie between entries 1 and 9
   task automatic test_basic_set();
      send_pixel(make_pixel(0, 0, 0, 0));
      send_pixel(make_pixel(255, 255, 255, 0));
      send_pixel(make_pixel(230, 0, 0, 0));
      send_pixel(make_pixel(92, 92, 255, 0));
      send_pixel(make_pixel(127, 127, 127, 0));
      send_pixel(make_pixel(229, 229, 229, 0));
      send_pixel(make_pixel(0, 0, 238, 0));
   endtask

   // Full search: extremes, gray ramp ends, and a tie between cube levels
   task automatic test_full_search();
      write_fast_mode(1'b0);
      send_pixel(make_pixel(0, 0, 0, 1));
      send_pixel(make_pixel(255, 255, 255, 1));
      send_pixel(make_pixel(115, 0, 0, 1));
      send_pixel(make_pixel(8, 8, 8, 1));
      send_pixel(make_pixel(238, 238, 238, 1));
      send_pixel(make_pixel(128, 128, 128, 1));
      send_pixel(make_pixel(255, 0, 128, 1));
   endtask

   // Fast mode: gray steps, clamp above the ramp, cube thresholds, basic set
   task automatic test_threshold_mode();
      write_fast_mode(1'b1);
      send_pixel(make_pixel(0, 0, 0, 1));
      send_pixel(make_pixel(12, 12, 12, 1));
      send_pixel(make_pixel(13, 22, 14, 1));
      send_pixel(make_pixel(242, 242, 242, 1));
      send_pixel(make_pixel(243, 243, 243, 1));
      send_pixel(make_pixel(255, 255, 255, 1));
      send_pixel(make_pixel(52, 53, 115, 1));
      send_pixel(make_pixel(116, 155, 156, 1));
      send_pixel(make_pixel(196, 235, 236, 1));
      send_pixel(make_pixel(0, 255, 0, 0));
   endtask

   // Random pixels under one mode, with a stretch of back-to-back traffic
   task automatic test_random_traffic(input logic fast, input int count);
      int i;
      write_fast_mode(fast);
      for (i = 0; i < count; i++) begin
         steady_flow = (i >= count / 2) && (i < count / 2 + 40);
         send_pixel(random_pixel($urandom_range(0, 3) != 0));
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      color_guess_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("error: result %0d with no item pending", rsp_color_index);
         end else begin
            want = pending_colors.pop_front();
            if (rsp_color_index !== want.index) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: rgb %0d,%0d,%0d select %0d: expected %0d, got %0d",
                           want.px.red, want.px.green, want.px.blue,
                           want.px.palette_select, want.index, rsp_color_index);
            end
         end
      end
   end

   // Receiver stalls: runs of random length, none in steady stretches
   initial begin : drive_rsp_stall
      int hold;
      forever begin
         hold = pick_delay();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      error_count        = 0;
      steady_flow        = 1'b0;
      model_fast_mode    = 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_red            <= 8'd0;
      req_green          <= 8'd0;
      req_blue           <= 8'd0;
      req_palette_select <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_set();
      test_full_search();
      test_threshold_mode();
      test_random_traffic(1'b0, 350);
      test_random_traffic(1'b1, 350);
      test_random_traffic(1'b0, 250);
      test_random_traffic(1'b1, 250);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_colors.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #6_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
